>>> src/db4_dwt_analysis_assert.svh
// ----------------------------------------------------------------------------
// Db4 DWT analysis assertion macros
// Concurrent assertion wrappers clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DB4_DWT_ANALYSIS_ASSERT_SVH
`define DB4_DWT_ANALYSIS_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DB4_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DB4_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DB4_ASSERT_SAME(lbl, ante, cons)
`define DB4_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/db4dwt_pkg.sv
// ----------------------------------------------------------------------------
// Db4 DWT analysis package
// Tap constants, Q1.16 filter coefficients and the tap control word type.
// ----------------------------------------------------------------------------
package db4dwt_pkg;

    localparam int TAPS            = 8;
    localparam int TAP_W           = $clog2(TAPS);
    localparam int COEF_W          = 17;
    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    // low-pass set; high-pass is the quadrature mirror
    localparam logic signed [COEF_W-1:0] LO_COEF [TAPS] = '{
        17'sd15098, 17'sd46848, 17'sd41345, -17'sd1834,
        -17'sd12258, 17'sd2021, 17'sd2155, -17'sd695
    };
    localparam logic signed [COEF_W-1:0] HI_COEF [TAPS] = '{
        -17'sd695, -17'sd2155, 17'sd2021, 17'sd12258,
        -17'sd1834, -17'sd41345, 17'sd46848, -17'sd15098
    };

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             use_x;   // tap 0: new sample, not the RAM
        logic             zero;    // history slot not yet filled
        logic             ch;
        logic [TAP_W-1:0] k;
    } t_tap_ctl;

endpackage

>>> src/db4dwt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module db4dwt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // a read and a write to one address in a cycle return the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/db4dwt_seq.sv
// ----------------------------------------------------------------------------
// Db4 DWT tap sequencer
// Per-channel ring pointers, fill counts and phase; writes each sample into
// the history RAM and walks the eight taps of an even-phase sample.
// ----------------------------------------------------------------------------
module db4dwt_seq
    import db4dwt_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int ADDR_W      = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_ch,
    input  logic [SAMPLE_BITS-1:0] i_x,
    input  logic                   i_pend_full,
    output logic                   o_take,
    output logic                   o_start,
    output logic                   o_we,
    output logic [ADDR_W-1:0]      o_waddr,
    output logic [SAMPLE_BITS-1:0] o_wdata,
    output logic                   o_re,
    output logic [ADDR_W-1:0]      o_raddr,
    output t_tap_ctl               o_ctl,
    output logic [SAMPLE_BITS-1:0] o_x
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                   r_busy;
    logic [TAP_W-1:0]       r_tap;
    logic                   r_ch;
    logic [CH_W-1:0]        r_chi;
    logic [TAP_W-1:0]       r_ptr;
    logic [TAP_W-1:0]       r_fill;
    logic [SAMPLE_BITS-1:0] r_x;
    t_tap_ctl               r_ctl;
    logic [TAP_W-1:0]       r_wptr [CHANNELS];
    logic [TAP_W-1:0]       r_cnt  [CHANNELS];
    logic [CHANNELS-1:0]    r_phase;

    logic            in_range;
    logic [CH_W-1:0] chi;
    logic            last_tap;
    logic            is_even;
    t_tap_ctl        n_ctl;

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [CH_W-1:0] c,
                                                  input logic [TAP_W-1:0] s);
        logic [CH_W+TAP_W-1:0] full;
        full = {c, s};
        return full[ADDR_W-1:0];
    endfunction

    assign in_range = (int'(i_ch) < CHANNELS);
    assign chi      = CH_W'(i_ch);
    assign last_tap = r_busy && (r_tap == TAP_W'(TAPS - 1));
    assign is_even  = in_range && !r_phase[chi];

    // next item enters on the last tap of the current one
    assign o_take  = i_valid && (!r_busy || last_tap) && (!is_even || !i_pend_full);
    assign o_start = o_take && is_even;

    assign o_we    = o_take && in_range;
    assign o_waddr = mk_addr(chi, r_wptr[chi]);
    assign o_wdata = i_x;

    // tap k reads the sample k steps back in the ring
    assign o_re    = r_busy && (r_tap != '0);
    assign o_raddr = mk_addr(r_chi, r_ptr - r_tap);

    always_comb begin
        n_ctl       = '0;
        n_ctl.valid = r_busy;
        n_ctl.first = (r_tap == '0);
        n_ctl.last  = last_tap;
        n_ctl.use_x = (r_tap == '0);
        n_ctl.zero  = (r_tap > r_fill);
        n_ctl.ch    = r_ch;
        n_ctl.k     = r_tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_tap   <= '0;
            r_ctl   <= '0;
            r_phase <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wptr[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            r_ctl <= n_ctl;
            if (r_busy) begin
                r_tap <= r_tap + 1'b1;
                if (last_tap) begin
                    r_busy <= 1'b0;
                end
            end
            if (o_start) begin
                r_busy <= 1'b1;
                r_tap  <= '0;
            end
            if (o_we) begin
                r_wptr[chi]  <= r_wptr[chi] + 1'b1;
                r_phase[chi] <= ~r_phase[chi];
                if (r_cnt[chi] != TAP_W'(TAPS - 1)) begin
                    r_cnt[chi] <= r_cnt[chi] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_start) begin
            r_ch   <= i_ch;
            r_chi  <= chi;
            r_ptr  <= r_wptr[chi];
            r_fill <= r_cnt[chi];
            r_x    <= i_x;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;

endmodule

>>> src/db4dwt_mac.sv
// ----------------------------------------------------------------------------
// Db4 DWT multiply-accumulate pair
// Low-pass and high-pass products per tap, accumulation, round and saturate.
// ----------------------------------------------------------------------------
module db4dwt_mac
    import db4dwt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tap_ctl               i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_x,
    input  logic [SAMPLE_BITS-1:0] i_rdata,
    output logic                   o_valid,
    output logic                   o_ch,
    output logic [SAMPLE_BITS-1:0] o_approx,
    output logic [SAMPLE_BITS-1:0] o_detail
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam int ACC_W  = SAMPLE_BITS + 18;   // sum of |coef| < 2^17

    logic signed [SAMPLE_BITS-1:0] op;
    logic signed [PROD_W-1:0]      prod_lo;
    logic signed [PROD_W-1:0]      prod_hi;

    logic                     r_pvalid;
    logic                     r_pfirst;
    logic                     r_plast;
    logic                     r_pch;
    logic signed [PROD_W-1:0] r_plo;
    logic signed [PROD_W-1:0] r_phi;
    logic signed [ACC_W-1:0]  r_acc_lo;
    logic signed [ACC_W-1:0]  r_acc_hi;
    logic                     r_done;
    logic                     r_och;

    // add half an LSB, floor by 2^16, clamp to the sample range
    function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0]           v;
        logic [ACC_W-16:0]        q;
        logic [SAMPLE_BITS-1:0]   res;
        v = {acc[ACC_W-1], acc} + (ACC_W+1)'(32768);
        q = v[ACC_W:16];
        if (q[ACC_W-16:SAMPLE_BITS-1] == '0 || q[ACC_W-16:SAMPLE_BITS-1] == '1) begin
            res = q[SAMPLE_BITS-1:0];
        end else if (q[ACC_W-16]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb begin
        if (i_ctl.use_x) begin
            op = i_x;
        end else if (i_ctl.zero) begin
            op = '0;
        end else begin
            op = i_rdata;
        end
        prod_lo = op * LO_COEF[i_ctl.k];
        prod_hi = op * HI_COEF[i_ctl.k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.valid;
            r_done   <= r_pvalid && r_plast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfirst <= i_ctl.first;
        r_plast  <= i_ctl.last;
        r_pch    <= i_ctl.ch;
        r_plo    <= prod_lo;
        r_phi    <= prod_hi;
        if (r_pvalid) begin
            r_och <= r_pch;
            if (r_pfirst) begin
                r_acc_lo <= ACC_W'(r_plo);
                r_acc_hi <= ACC_W'(r_phi);
            end else begin
                r_acc_lo <= r_acc_lo + ACC_W'(r_plo);
                r_acc_hi <= r_acc_hi + ACC_W'(r_phi);
            end
        end
    end

    assign o_valid  = r_done;
    assign o_ch     = r_och;
    assign o_approx = round_sat(r_acc_lo);
    assign o_detail = round_sat(r_acc_hi);

endmodule

>>> src/db4_dwt_analysis.sv
// ----------------------------------------------------------------------------
// Db4 DWT analysis stage
// One level of Db4 wavelet analysis per channel, decimated by two.
//
//   channel   dir  tdata                          tuser
//   s (in)    in   sample                         channel
//   m (out)   out  approx, detail                 out_channel
//
// An even-phase sample runs one tap per cycle through the shared low/high
// multiply-accumulate pair, seven of its eight taps read from the history
// RAM on its single read port; an odd-phase sample is a RAM write only. Each
// result passes the tap control, product and accumulator registers in turn.
// Reset is synchronous; per-channel fill counts make unwritten history read as
// zero, so no RAM clearing pass is needed. A two-word output buffer lets work
// continue while a result waits; even samples hold off only when two results
// are already outstanding.
// ----------------------------------------------------------------------------
module db4_dwt_analysis
    import db4dwt_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_TD_W    = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TD_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [IN_TD_W-1:0]  i_s_tdata,   // sample
    input  logic                i_s_tuser,   // channel
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OUT_TD_W-1:0] o_m_tdata,   // approx, detail
    output logic                o_m_tuser    // out_channel
);

    `include "db4_dwt_analysis_assert.svh"

    localparam int DEPTH  = CHANNELS * TAPS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                   r_in_valid;
    logic                   r_in_ch;
    logic [SAMPLE_BITS-1:0] r_in_x;

    logic                   seq_take;
    logic                   seq_start;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    t_tap_ctl               tap_ctl;
    logic [SAMPLE_BITS-1:0] tap_x;

    logic                   mac_valid;
    logic                   mac_ch;
    logic [SAMPLE_BITS-1:0] mac_approx;
    logic [SAMPLE_BITS-1:0] mac_detail;

    logic [1:0]             r_pend;      // even samples started, results not yet taken
    logic                   r_ob_ch [2];
    logic [SAMPLE_BITS-1:0] r_ob_a  [2];
    logic [SAMPLE_BITS-1:0] r_ob_d  [2];
    logic                   r_ob_wp;
    logic                   r_ob_rp;
    logic [1:0]             r_ob_cnt;
    logic                   pop;

    // input register
    assign o_s_tready = !r_in_valid || seq_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (seq_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch <= i_s_tuser;
            r_in_x  <= i_s_tdata[SAMPLE_BITS-1:0];
        end
    end

    db4dwt_seq #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_ch        (r_in_ch),
        .i_x         (r_in_x),
        .i_pend_full (r_pend == 2'd2),
        .o_take      (seq_take),
        .o_start     (seq_start),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .o_ctl       (tap_ctl),
        .o_x         (tap_x)
    );

    db4dwt_ram #(
        .WIDTH   (SAMPLE_BITS),
        .DEPTH   (DEPTH),
        .AW      (ADDR_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    db4dwt_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (tap_ctl),
        .i_x      (tap_x),
        .i_rdata  (ram_rdata),
        .o_valid  (mac_valid),
        .o_ch     (mac_ch),
        .o_approx (mac_approx),
        .o_detail (mac_detail)
    );

    // output buffer, two words deep
    assign pop = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= '0;
        end else begin
            r_pend   <= r_pend + {1'b0, seq_start} - {1'b0, pop};
            r_ob_cnt <= r_ob_cnt + {1'b0, mac_valid} - {1'b0, pop};
            if (mac_valid) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac_valid) begin
            r_ob_ch[r_ob_wp] <= mac_ch;
            r_ob_a[r_ob_wp]  <= mac_approx;
            r_ob_d[r_ob_wp]  <= mac_detail;
        end
    end

    assign o_m_tvalid = (r_ob_cnt != 2'd0);
    assign o_m_tuser  = r_ob_ch[r_ob_rp];
    assign o_m_tdata  = OUT_TD_W'({r_ob_d[r_ob_rp], r_ob_a[r_ob_rp]});

    `DB4_ASSERT_SAME(a_ob_no_overflow, mac_valid, r_ob_cnt != 2'd2)
    `DB4_ASSERT_SAME(a_ob_within_pend, 1'b1, r_ob_cnt <= r_pend)
    `DB4_ASSERT_SAME(a_result_was_started, mac_valid, r_pend != 2'd0)
    `DB4_ASSERT_NEXT(a_start_counted, seq_start, r_pend != 2'd0)

endmodule

>>> tb/db4_dwt_analysis_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Db4 DWT analysis stage testbench
// Streams channel-tagged Q1.23 samples into the stage. A local filter-bank
// model predicts each decimated approx/detail pair, and every output word is
// checked against it in order. Directed extremes come first, then random
// traffic with random idle bursts, a long output hold-off and an idle-free
// tail.
// ----------------------------------------------------------------------------
module db4_dwt_analysis_tb;

    localparam int SW       = db4dwt_pkg::SAMPLE_BITS_DEF;
    localparam int NCH      = db4dwt_pkg::CHANNELS_DEF;
    localparam int NTAPS    = 8;
    localparam int IN_TD_W  = ((SW + 7) / 8) * 8;
    localparam int OUT_TD_W = ((2 * SW + 7) / 8) * 8;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    // Q1.16 Db4 taps; high-pass is the mirrored, sign-alternated low-pass set
    localparam longint LP_TAPS [NTAPS] = '{15098, 46848, 41345, -1834,
                                           -12258, 2021, 2155, -695};
    localparam longint HP_TAPS [NTAPS] = '{-695, -2155, 2021, 12258,
                                           -1834, -41345, 46848, -15098};

    typedef struct packed {
        logic          ch;
        logic [SW-1:0] approx;
        logic [SW-1:0] detail;
    } t_coef_pair;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [IN_TD_W-1:0]  i_s_tdata;    // sample
    logic                i_s_tuser;    // channel
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_TD_W-1:0] o_m_tdata;    // approx, detail
    logic                o_m_tuser;    // out_channel

    t_coef_pair pending_pairs[$];
    longint     chan_hist [NCH][NTAPS-1];
    logic       chan_odd [NCH];
    int         fail_cnt;
    bit         tx_idle_en;
    bit         rx_idle_en;
    int         rx_hold_req;

    db4_dwt_analysis dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [SW-1:0] round_q123(input longint acc);
        longint q;
        q = (acc + 32768) >>> 16;   // floor, ties toward +inf
        if (q > longint'(S_MAX))
            q = longint'(S_MAX);
        if (q < longint'(S_MIN))
            q = longint'(S_MIN);
        return q[SW-1:0];
    endfunction

    // filter-bank state update for one accepted word
    function automatic void predict_pair(input logic ch, input logic signed [SW-1:0] x);
        longint     acc_lp;
        longint     acc_hp;
        t_coef_pair p;
        int         k;
        if (!chan_odd[ch]) begin
            acc_lp = LP_TAPS[0] * longint'(x);
            acc_hp = HP_TAPS[0] * longint'(x);
            for (k = 1; k < NTAPS; k++) begin
                acc_lp += LP_TAPS[k] * chan_hist[ch][k-1];
                acc_hp += HP_TAPS[k] * chan_hist[ch][k-1];
            end
            p.ch     = ch;
            p.approx = round_q123(acc_lp);
            p.detail = round_q123(acc_hp);
            pending_pairs.push_back(p);
        end
        for (k = NTAPS - 2; k > 0; k--)
            chan_hist[ch][k] = chan_hist[ch][k-1];
        chan_hist[ch][0] = longint'(x);
        chan_odd[ch] = ~chan_odd[ch];
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return SW'($urandom_range(0, 1023)) - SW'(512);
            3: return SW'(32'($urandom_range(0, 3)) << 15);
            default: return SW'($urandom());
        endcase
    endfunction

    task automatic send_sample(input logic ch, input logic [SW-1:0] smp);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            i_s_tdata  = IN_TD_W'($urandom());
            i_s_tuser  = 1'($urandom());
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = IN_TD_W'(smp);
        i_s_tuser  = ch;
        do @(posedge i_clk); while (!o_s_tready);
        predict_pair(ch, smp);
    endtask

    task automatic test_directed();
        int i;
        // start of stream: history still reads zero
        for (i = 0; i < 5; i++) begin
            send_sample(1'b0, S_MAX);
            send_sample(1'b1, S_MIN);
        end
        // alternating full scale drives the detail sum into saturation
        for (i = 0; i < 10; i++)
            send_sample(1'b0, (i % 2) ? S_MIN : S_MAX);
        send_sample(1'b1, SW'(1));
        send_sample(1'b1, SW'(32768));    // rounding ties on odd taps
        send_sample(1'b1, -SW'(32768));
        send_sample(1'b1, SW'(0));
        send_sample(1'b1, -SW'(1));
        send_sample(1'b0, SW'(0));
        send_sample(1'b0, SW'(0));
    endtask

    task automatic test_random_stream(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_sample(1'($urandom()), rand_sample());
    endtask

    // output held off for a long stretch while input keeps coming
    task automatic test_backpressure();
        int i;
        tx_idle_en  = 1'b0;
        rx_hold_req = 300;
        for (i = 0; i < 60; i++)
            send_sample(1'($urandom()), rand_sample());
        tx_idle_en = 1'b1;
    endtask

    task automatic test_no_idle(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_stream(n);
    endtask

    // output-side ready: random stall bursts and the long hold-off
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0) begin
                i_m_tready = 1'b0;
                hold--;
            end else if (stall > 0) begin
                i_m_tready = 1'b0;
                stall--;
            end else begin
                i_m_tready = 1'b1;
                if (rx_idle_en && $urandom_range(0, 5) == 0)
                    stall = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge i_clk) begin
        t_coef_pair    exp_p;
        logic [SW-1:0] act_a;
        logic [SW-1:0] act_d;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act_a = o_m_tdata[SW-1:0];
            act_d = o_m_tdata[2*SW-1:SW];
            if (pending_pairs.size() == 0) begin
                $error("unexpected output word: ch %0d approx %0d detail %0d",
                       o_m_tuser, $signed(act_a), $signed(act_d));
                fail_cnt++;
            end else begin
                exp_p = pending_pairs.pop_front();
                if (o_m_tuser !== exp_p.ch) begin
                    $error("out_channel mismatch: expected %0d, actual %0d",
                           exp_p.ch, o_m_tuser);
                    fail_cnt++;
                end
                if (act_a !== exp_p.approx) begin
                    $error("approx mismatch: expected %0d, actual %0d",
                           $signed(exp_p.approx), $signed(act_a));
                    fail_cnt++;
                end
                if (act_d !== exp_p.detail) begin
                    $error("detail mismatch: expected %0d, actual %0d",
                           $signed(exp_p.detail), $signed(act_d));
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        fail_cnt    = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold_req = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        for (int c = 0; c < NCH; c++) begin
            chan_odd[c] = 1'b0;
            for (int k = 0; k < NTAPS - 1; k++)
                chan_hist[c][k] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_stream(400);
        test_backpressure();
        test_random_stream(250);
        test_no_idle(170);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge i_clk);
        // odd-phase words give no output; let any stray word surface
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/db4dwt_pkg.sv
src/db4dwt_ram.sv
src/db4dwt_seq.sv
src/db4dwt_mac.sv
src/db4_dwt_analysis.sv
tb/db4_dwt_analysis_tb.sv
